[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/osa_pkg.sv]
package osa_pkg;

  // monitor states
  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_COUNTDOWN = 2'd1,
    ST_DURATION  = 2'd2,
    ST_STILLNESS = 2'd3
  } state_t;

  // transition reasons
  typedef enum logic [2:0] {
    RSN_MOTION_ABOVE    = 3'd0,
    RSN_MOTION_BELOW    = 3'd1,
    RSN_DOOR_OPENED     = 3'd2,
    RSN_COUNTDOWN_DONE  = 3'd3,
    RSN_DURATION_ALERT  = 3'd4,
    RSN_STILLNESS_ALERT = 3'd5
  } reason_t;

  // door sensor codes
  localparam logic [1:0] DOOR_CLOSED = 2'd1;
  localparam logic [1:0] DOOR_OPEN   = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOTION_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNTDOWN_LIMIT  = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION_LIMIT   = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STILLNESS_LIMIT  = 4'd3;

  // register reset values before truncation to the field width
  localparam logic [63:0] MOTION_THRESHOLD_RST = 64'd60;
  localparam logic [63:0] COUNTDOWN_LIMIT_RST  = 64'd15000;
  localparam logic [63:0] DURATION_LIMIT_RST   = 64'd1200000;
  localparam logic [63:0] STILLNESS_LIMIT_RST  = 64'd120000;

endpackage

[src/osa_poll_if.sv]
interface osa_poll_if #(
  parameter int TIME_BITS   = 32,
  parameter int MOTION_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic [TIME_BITS-1:0]   now_ms;
  logic [1:0]             door_state;
  logic [MOTION_BITS-1:0] motion_level;

  modport source (output valid, output now_ms, output door_state, output motion_level,
                  input ready);
  modport sink (input valid, input now_ms, input door_state, input motion_level,
                output ready);
endinterface

[src/osa_result_if.sv]
interface osa_result_if #(
  parameter int TIME_BITS = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           current_state;
  logic                 changed;
  logic [1:0]           left_state;
  logic [2:0]           reason_code;
  logic [TIME_BITS-1:0] time_in_left_state;
  logic [TIME_BITS-1:0] state_elapsed;

  modport source (output valid, output current_state, output changed, output left_state,
                  output reason_code, output time_in_left_state, output state_elapsed,
                  input ready);
  modport sink (input valid, input current_state, input changed, input left_state,
                input reason_code, input time_in_left_state, input state_elapsed,
                output ready);
endinterface

[src/osa_cfg_if.sv]
interface osa_cfg_if #(
  parameter int DATA_BITS = 32
) ();
  logic                                valid;
  logic                                ready;
  logic [osa_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]                data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/osa_cfg_regs.sv]
module osa_cfg_regs #(
  parameter int TIME_BITS   = 32,
  parameter int MOTION_BITS = 16,
  parameter int DATA_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [osa_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [DATA_BITS-1:0]               wr_data,
  output logic [MOTION_BITS-1:0]             motion_threshold,
  output logic [TIME_BITS-1:0]               countdown_limit_ms,
  output logic [TIME_BITS-1:0]               duration_limit_ms,
  output logic [TIME_BITS-1:0]               stillness_limit_ms
);

  // register file, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold   <= MOTION_BITS'(osa_pkg::MOTION_THRESHOLD_RST);
      countdown_limit_ms <= TIME_BITS'(osa_pkg::COUNTDOWN_LIMIT_RST);
      duration_limit_ms  <= TIME_BITS'(osa_pkg::DURATION_LIMIT_RST);
      stillness_limit_ms <= TIME_BITS'(osa_pkg::STILLNESS_LIMIT_RST);
    end else if (wr_en) begin
      unique case (wr_index)
        osa_pkg::REG_MOTION_THRESHOLD: motion_threshold   <= wr_data[MOTION_BITS-1:0];
        osa_pkg::REG_COUNTDOWN_LIMIT:  countdown_limit_ms <= wr_data[TIME_BITS-1:0];
        osa_pkg::REG_DURATION_LIMIT:   duration_limit_ms  <= wr_data[TIME_BITS-1:0];
        osa_pkg::REG_STILLNESS_LIMIT:  stillness_limit_ms <= wr_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/occupancy_stillness_alarm_fsm.sv]
// channel    | direction | interface     | carries
// poll_in    | sink      | osa_poll_if   | now_ms, door_state, motion_level
// result_out | source    | osa_result_if | current_state, changed, left_state, reason_code,
//            |           |               | time_in_left_state, state_elapsed
// cfg        | sink      | osa_cfg_if    | index, data (always ready)
//
// a poll lands in the input register when it is accepted, and the state step loads
// the result register from it once that register is free or being drained.
// one poll per cycle sustained while result_out.ready holds high; the step and state
// update sit between those two registers. a stalled result holds the step stage, and
// poll_in.ready drops only when both stages are full. synchronous reset puts the
// monitor in idle with all timestamps cleared and the limits at their default values.
module occupancy_stillness_alarm_fsm #(
  parameter int TIME_BITS   = 32,
  parameter int MOTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  osa_poll_if.sink             poll_in,
  osa_result_if.source         result_out,
  osa_cfg_if.sink              cfg
);

  localparam int CFG_BITS = (TIME_BITS > MOTION_BITS) ? TIME_BITS : MOTION_BITS;

  logic [MOTION_BITS-1:0] motion_threshold;
  logic [TIME_BITS-1:0]   countdown_limit_ms;
  logic [TIME_BITS-1:0]   duration_limit_ms;
  logic [TIME_BITS-1:0]   stillness_limit_ms;

  // input stage
  logic                   s1_valid;
  logic [TIME_BITS-1:0]   s1_now;
  logic [1:0]             s1_door;
  logic [MOTION_BITS-1:0] s1_motion;

  // monitor state
  osa_pkg::state_t        fsm_state, fsm_state_next;
  logic [TIME_BITS-1:0]   countdown_start, countdown_start_next;
  logic [TIME_BITS-1:0]   occupancy_start, occupancy_start_next;
  logic [TIME_BITS-1:0]   stillness_start, stillness_start_next;
  logic [TIME_BITS-1:0]   last_change_time, last_change_time_next;

  // step results
  osa_pkg::state_t        step_state;
  osa_pkg::reason_t       step_reason;
  logic                   step_changed;
  logic [TIME_BITS-1:0]   step_elapsed;
  logic                   above, below;
  logic [TIME_BITS-1:0]   el_countdown, el_occupancy, el_stillness;
  logic                   advance;

  // result register
  logic                   out_valid;
  osa_pkg::state_t        out_state;
  logic                   out_changed;
  osa_pkg::state_t        out_left;
  osa_pkg::reason_t       out_reason;
  logic [TIME_BITS-1:0]   out_time_in_left;
  logic [TIME_BITS-1:0]   out_elapsed;

  osa_cfg_regs #(
    .TIME_BITS   (TIME_BITS),
    .MOTION_BITS (MOTION_BITS),
    .DATA_BITS   (CFG_BITS)
  ) u_cfg_regs (
    .clk                (clk),
    .rst                (rst),
    .wr_en              (cfg.valid),
    .wr_index           (cfg.index),
    .wr_data            (cfg.data),
    .motion_threshold   (motion_threshold),
    .countdown_limit_ms (countdown_limit_ms),
    .duration_limit_ms  (duration_limit_ms),
    .stillness_limit_ms (stillness_limit_ms)
  );

  assign cfg.ready = 1'b1;

  // flow control: step stage moves when the result register is free or being drained
  assign advance       = s1_valid && (!out_valid || result_out.ready);
  assign poll_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll_in.ready) begin
      s1_valid <= poll_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_in.valid && poll_in.ready) begin
      s1_now    <= poll_in.now_ms;
      s1_door   <= poll_in.door_state;
      s1_motion <= poll_in.motion_level;
    end
  end

  // motion classification and timer differences
  assign above        = s1_motion > motion_threshold;
  assign below        = (s1_motion != '0) && (s1_motion < motion_threshold);
  assign el_countdown = s1_now - countdown_start;
  assign el_occupancy = s1_now - occupancy_start;
  assign el_stillness = s1_now - stillness_start;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state        <= osa_pkg::ST_IDLE;
      countdown_start  <= '0;
      occupancy_start  <= '0;
      stillness_start  <= '0;
      last_change_time <= '0;
    end else begin
      fsm_state        <= fsm_state_next;
      countdown_start  <= countdown_start_next;
      occupancy_start  <= occupancy_start_next;
      stillness_start  <= stillness_start_next;
      last_change_time <= last_change_time_next;
    end
  end

  // next state, checks in priority order: motion, door, timers
  always_comb begin
    step_state           = fsm_state;
    step_reason          = osa_pkg::RSN_MOTION_ABOVE;
    step_changed         = 1'b0;
    step_elapsed         = '0;
    countdown_start_next = countdown_start;
    occupancy_start_next = occupancy_start;
    stillness_start_next = stillness_start;
    unique case (fsm_state)
      osa_pkg::ST_IDLE: begin
        if (above && (s1_door == osa_pkg::DOOR_CLOSED)) begin
          step_state           = osa_pkg::ST_COUNTDOWN;
          step_reason          = osa_pkg::RSN_MOTION_ABOVE;
          step_changed         = 1'b1;
          countdown_start_next = s1_now;
        end
      end
      osa_pkg::ST_COUNTDOWN: begin
        step_elapsed = el_countdown;
        if (below) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_MOTION_BELOW;
          step_changed = 1'b1;
        end else if (s1_door == osa_pkg::DOOR_OPEN) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_DOOR_OPENED;
          step_changed = 1'b1;
        end else if (el_countdown >= countdown_limit_ms) begin
          step_state           = osa_pkg::ST_DURATION;
          step_reason          = osa_pkg::RSN_COUNTDOWN_DONE;
          step_changed         = 1'b1;
          occupancy_start_next = s1_now;
        end
      end
      osa_pkg::ST_DURATION: begin
        step_elapsed = el_occupancy;
        if (below) begin
          step_state           = osa_pkg::ST_STILLNESS;
          step_reason          = osa_pkg::RSN_MOTION_BELOW;
          step_changed         = 1'b1;
          stillness_start_next = s1_now;
        end else if (s1_door == osa_pkg::DOOR_OPEN) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_DOOR_OPENED;
          step_changed = 1'b1;
        end else if (el_occupancy >= duration_limit_ms) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_DURATION_ALERT;
          step_changed = 1'b1;
        end
      end
      osa_pkg::ST_STILLNESS: begin
        step_elapsed = el_stillness;
        if (above) begin
          step_state   = osa_pkg::ST_DURATION;
          step_reason  = osa_pkg::RSN_MOTION_ABOVE;
          step_changed = 1'b1;
        end else if (s1_door == osa_pkg::DOOR_OPEN) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_DOOR_OPENED;
          step_changed = 1'b1;
        end else if (el_occupancy >= duration_limit_ms) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_DURATION_ALERT;
          step_changed = 1'b1;
        end else if (el_stillness >= stillness_limit_ms) begin
          step_state   = osa_pkg::ST_IDLE;
          step_reason  = osa_pkg::RSN_STILLNESS_ALERT;
          step_changed = 1'b1;
        end
      end
      default: ;
    endcase

    // commit only when the item actually moves to the result register
    if (advance && step_changed) begin
      fsm_state_next        = step_state;
      last_change_time_next = s1_now;
    end else begin
      fsm_state_next        = fsm_state;
      last_change_time_next = last_change_time;
    end
    if (!advance) begin
      countdown_start_next = countdown_start;
      occupancy_start_next = occupancy_start;
      stillness_start_next = stillness_start;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state        <= step_state;
      out_changed      <= step_changed;
      out_left         <= step_changed ? fsm_state : osa_pkg::ST_IDLE;
      out_reason       <= step_reason;
      out_time_in_left <= step_changed ? (s1_now - last_change_time) : '0;
      out_elapsed      <= step_elapsed;
    end
  end

  assign result_out.valid              = out_valid;
  assign result_out.current_state      = out_state;
  assign result_out.changed            = out_changed;
  assign result_out.left_state         = out_left;
  assign result_out.reason_code        = out_reason;
  assign result_out.time_in_left_state = out_time_in_left;
  assign result_out.state_elapsed      = out_elapsed;

endmodule

[src/osa_checker.sv]
`include "assert_macros.svh"

module osa_checker #(
  parameter int TIME_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           current_state,
  input logic                 changed,
  input logic [1:0]           left_state,
  input logic [2:0]           reason_code,
  input logic [TIME_BITS-1:0] time_in_left_state,
  input logic [TIME_BITS-1:0] state_elapsed
);

  // a waiting result is not withdrawn
  `ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)

  // without a transition the transition fields read zero
  `ASSERT_IMPLY(a_quiet_fields, clk, rst, out_valid && !changed,
                left_state == 2'd0 && reason_code == 3'd0 && time_in_left_state == '0)

  // a transition always lands in a different state
  `ASSERT_IMPLY(a_real_change, clk, rst, out_valid && changed, current_state != left_state)

  // leaving idle only happens on strong motion into countdown, with no timer running
  `ASSERT_IMPLY(a_idle_exit, clk, rst,
                out_valid && changed && left_state == osa_pkg::ST_IDLE,
                current_state == osa_pkg::ST_COUNTDOWN &&
                reason_code == osa_pkg::RSN_MOTION_ABOVE && state_elapsed == '0)

  // countdown done moves countdown to duration
  `ASSERT_IMPLY(a_countdown_done, clk, rst,
                out_valid && changed && reason_code == osa_pkg::RSN_COUNTDOWN_DONE,
                left_state == osa_pkg::ST_COUNTDOWN &&
                current_state == osa_pkg::ST_DURATION)

endmodule

bind occupancy_stillness_alarm_fsm osa_checker #(
  .TIME_BITS (TIME_BITS)
) u_osa_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (result_out.valid),
  .out_ready          (result_out.ready),
  .current_state      (result_out.current_state),
  .changed            (result_out.changed),
  .left_state         (result_out.left_state),
  .reason_code        (result_out.reason_code),
  .time_in_left_state (result_out.time_in_left_state),
  .state_elapsed      (result_out.state_elapsed)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps

package occ_tb_pkg;
  import osa_pkg::*;

  localparam int TIME_W   = 32;
  localparam int MOTION_W = 16;
  localparam int CFG_W    = 32;

  // door codes that count as neither closed nor open
  localparam logic [1:0] DOOR_UNKNOWN  = 2'd0;
  localparam logic [1:0] DOOR_BAD_CODE = 2'd3;

  // register indexes past the last register, writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 4'd15;

  typedef struct {
    state_t              state;
    logic                changed;
    state_t              left;
    reason_t             reason;
    logic [TIME_W-1:0]   time_in_left;
    logic [TIME_W-1:0]   elapsed;
  } occ_result_t;

  // occupancy monitor predictor plus the queue of results it owes
  class occupancy_scoreboard;
    logic [MOTION_W-1:0] motion_thr;
    logic [TIME_W-1:0]   countdown_limit;
    logic [TIME_W-1:0]   duration_limit;
    logic [TIME_W-1:0]   stillness_limit;
    state_t              state;
    logic [TIME_W-1:0]   countdown_start;
    logic [TIME_W-1:0]   occupancy_start;
    logic [TIME_W-1:0]   stillness_start;
    logic [TIME_W-1:0]   last_change;
    occ_result_t         owed_q[$];
    int                  n_errors;
    int                  n_checked;
    int                  n_polls;
    int                  reason_hits[6];

    function new();
      motion_thr      = MOTION_THRESHOLD_RST[MOTION_W-1:0];
      countdown_limit = COUNTDOWN_LIMIT_RST[TIME_W-1:0];
      duration_limit  = DURATION_LIMIT_RST[TIME_W-1:0];
      stillness_limit = STILLNESS_LIMIT_RST[TIME_W-1:0];
      state           = ST_IDLE;
      countdown_start = '0;
      occupancy_start = '0;
      stillness_start = '0;
      last_change     = '0;
      n_errors        = 0;
      n_checked       = 0;
      n_polls         = 0;
      foreach (reason_hits[i]) reason_hits[i] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_failure(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // register write, values cut to the register width
    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MOTION_THRESHOLD: motion_thr = data[MOTION_W-1:0];
        REG_COUNTDOWN_LIMIT:  countdown_limit = data[TIME_W-1:0];
        REG_DURATION_LIMIT:   duration_limit = data[TIME_W-1:0];
        REG_STILLNESS_LIMIT:  stillness_limit = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted poll: step the state machine and queue its result
    function void note_poll(logic [TIME_W-1:0] now, logic [1:0] door,
                            logic [MOTION_W-1:0] motion);
      occ_result_t       r;
      state_t            nxt;
      reason_t           why;
      logic              chg;
      logic              closed;
      logic              opened;
      logic              above;
      logic              below;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] session;
      closed  = (door == DOOR_CLOSED);
      opened  = (door == DOOR_OPEN);
      above   = (motion > motion_thr);
      below   = (motion != '0) && (motion < motion_thr);
      nxt     = state;
      why     = RSN_MOTION_ABOVE;
      chg     = 1'b0;
      elapsed = '0;
      session = now - occupancy_start;
      n_polls++;
      case (state)
        ST_IDLE: begin
          if (above && closed) begin
            nxt = ST_COUNTDOWN; why = RSN_MOTION_ABOVE; chg = 1'b1;
            countdown_start = now;
          end
        end
        ST_COUNTDOWN: begin
          elapsed = now - countdown_start;
          if (below) begin
            nxt = ST_IDLE; why = RSN_MOTION_BELOW; chg = 1'b1;
          end else if (opened) begin
            nxt = ST_IDLE; why = RSN_DOOR_OPENED; chg = 1'b1;
          end else if (elapsed >= countdown_limit) begin
            nxt = ST_DURATION; why = RSN_COUNTDOWN_DONE; chg = 1'b1;
            occupancy_start = now;
          end
        end
        ST_DURATION: begin
          elapsed = session;
          if (below) begin
            nxt = ST_STILLNESS; why = RSN_MOTION_BELOW; chg = 1'b1;
            stillness_start = now;
          end else if (opened) begin
            nxt = ST_IDLE; why = RSN_DOOR_OPENED; chg = 1'b1;
          end else if (elapsed >= duration_limit) begin
            nxt = ST_IDLE; why = RSN_DURATION_ALERT; chg = 1'b1;
          end
        end
        default: begin
          // stillness: the session timer keeps running from occupancy start
          elapsed = now - stillness_start;
          if (above) begin
            nxt = ST_DURATION; why = RSN_MOTION_ABOVE; chg = 1'b1;
          end else if (opened) begin
            nxt = ST_IDLE; why = RSN_DOOR_OPENED; chg = 1'b1;
          end else if (session >= duration_limit) begin
            nxt = ST_IDLE; why = RSN_DURATION_ALERT; chg = 1'b1;
          end else if (elapsed >= stillness_limit) begin
            nxt = ST_IDLE; why = RSN_STILLNESS_ALERT; chg = 1'b1;
          end
        end
      endcase
      r.state        = nxt;
      r.changed      = chg;
      r.left         = chg ? state : ST_IDLE;
      r.reason       = chg ? why : RSN_MOTION_ABOVE;
      r.time_in_left = chg ? (now - last_change) : '0;
      r.elapsed      = elapsed;
      if (chg) begin
        last_change = now;
        state       = nxt;
        reason_hits[int'(why)]++;
      end
      owed_q.push_back(r);
    endfunction

    // compare one delivered result with the oldest one owed
    function void check_result(occ_result_t got);
      occ_result_t want;
      string       diffs;
      n_checked++;
      if (owed_q.size() == 0) begin
        note_failure($sformatf("result %0d arrived with no poll outstanding (state %0d)",
                               n_checked, got.state));
        return;
      end
      want  = owed_q.pop_front();
      diffs = "";
      if (got.state !== want.state)
        diffs = {diffs, $sformatf(" current_state exp %0d got %0d", want.state, got.state)};
      if (got.changed !== want.changed)
        diffs = {diffs, $sformatf(" changed exp %0d got %0d", want.changed, got.changed)};
      if (got.left !== want.left)
        diffs = {diffs, $sformatf(" left_state exp %0d got %0d", want.left, got.left)};
      if (got.reason !== want.reason)
        diffs = {diffs, $sformatf(" reason_code exp %0d got %0d", want.reason, got.reason)};
      if (got.time_in_left !== want.time_in_left)
        diffs = {diffs, $sformatf(" time_in_left_state exp %0d got %0d",
                                  want.time_in_left, got.time_in_left)};
      if (got.elapsed !== want.elapsed)
        diffs = {diffs, $sformatf(" state_elapsed exp %0d got %0d",
                                  want.elapsed, got.elapsed)};
      if (diffs != "") note_failure($sformatf("result %0d:%s", n_checked, diffs));
    endfunction

    function void flag_leftovers();
      if (owed_q.size() != 0)
        note_failure($sformatf("%0d results never delivered", owed_q.size()));
    endfunction
  endclass

endpackage

module tb_top;
  import osa_pkg::*;
  import occ_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int STEP_CAP       = 200000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;
  typedef enum logic [2:0] {MK_ABOVE, MK_BELOW, MK_EQUAL, MK_ZERO, MK_ANY} motion_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  osa_poll_if   #(.TIME_BITS(TIME_W), .MOTION_BITS(MOTION_W)) poll ();
  osa_result_if #(.TIME_BITS(TIME_W))                         res ();
  osa_cfg_if    #(.DATA_BITS(CFG_W))                          cfg ();

  occupancy_scoreboard occ_model = new();

  logic [TIME_W-1:0] poll_time = '0;
  int                quiet_cycles = 0;
  logic              rx_ready = 1'b0;
  logic [15:0]       rx_tick = '0;
  rx_mode_t          rx_mode = RX_ALWAYS;
  int                phase_count = 0;

  occupancy_stillness_alarm_fsm #(
    .TIME_BITS(TIME_W),
    .MOTION_BITS(MOTION_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .poll_in(poll),
    .result_out(res),
    .cfg(cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side stalls, a new pattern is picked whenever rx_tick[5:0] wraps to zero
  assign res.ready = rx_ready;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 16'd1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:   rx_ready <= 1'b1;
      RX_RANDOM:   rx_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: rx_ready <= (rx_tick[3:2] == 2'b00);
      default:     rx_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // check every delivered result
  always @(posedge clk) begin : result_watch
    occ_result_t seen;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      seen.state        = state_t'(res.current_state);
      seen.changed      = res.changed;
      seen.left         = state_t'(res.left_state);
      seen.reason       = reason_t'(res.reason_code);
      seen.time_in_left = res.time_in_left_state;
      seen.elapsed      = res.state_elapsed;
      occ_model.check_result(seen);
    end
  end

  // cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (poll.valid && poll.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAIL occupancy_stillness_alarm_fsm");
    $finish;
  end

  // present one poll and hold it until taken
  task automatic send_poll(input logic [TIME_W-1:0] now, input logic [1:0] door,
                           input logic [MOTION_W-1:0] motion);
    poll.valid        <= 1'b1;
    poll.now_ms       <= now;
    poll.door_state   <= door;
    poll.motion_level <= motion;
    do @(posedge clk); while (poll.ready !== 1'b1);
    occ_model.note_poll(now, door, motion);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    occ_model.write_reg(idx, data);
  endtask

  // stop sending and let every owed result come back
  task automatic wait_results_drained();
    poll.valid <= 1'b0;
    while (occ_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // motion mix leans toward whatever moves the current state along
  function automatic motion_kind_t pick_motion_kind(state_t s);
    int unsigned p;
    int unsigned c_above;
    int unsigned c_below;
    int unsigned c_equal;
    int unsigned c_zero;
    p = $urandom_range(0, 99);
    case (s)
      ST_IDLE:      begin c_above = 60; c_below = 70; c_equal = 80; c_zero = 90; end
      ST_COUNTDOWN: begin c_above = 30; c_below = 38; c_equal = 58; c_zero = 93; end
      ST_DURATION:  begin c_above = 25; c_below = 55; c_equal = 70; c_zero = 95; end
      default:      begin c_above = 15; c_below = 50; c_equal = 65; c_zero = 95; end
    endcase
    if (p < c_above) return MK_ABOVE;
    if (p < c_below) return MK_BELOW;
    if (p < c_equal) return MK_EQUAL;
    if (p < c_zero) return MK_ZERO;
    return MK_ANY;
  endfunction

  function automatic logic [MOTION_W-1:0] motion_of_kind(motion_kind_t k,
                                                         logic [MOTION_W-1:0] thr);
    int unsigned t;
    t = thr;
    case (k)
      MK_ABOVE: return (t == 32'hFFFF) ? MOTION_W'($urandom()) :
                       MOTION_W'($urandom_range(t + 1, 32'hFFFF));
      MK_BELOW: return (t > 1) ? MOTION_W'($urandom_range(1, t - 1)) : MOTION_W'(1);
      MK_EQUAL: return thr;
      MK_ZERO:  return '0;
      default:  return MOTION_W'($urandom());
    endcase
  endfunction

  // mostly plausible polls with time moving forward, some pure noise
  task automatic send_random_poll(input int unsigned step_max, input int unsigned long_step);
    int unsigned         p;
    logic [1:0]          door;
    logic [MOTION_W-1:0] motion;
    p = $urandom_range(0, 99);
    if (p < 3) poll_time = $urandom();
    else if (p < 6) poll_time = poll_time + $urandom();
    else if (p < 12) poll_time = poll_time + $urandom_range(0, long_step);
    else poll_time = poll_time + $urandom_range(0, step_max);
    if ($urandom_range(0, 9) == 0) begin
      door   = 2'($urandom_range(0, 3));
      motion = MOTION_W'($urandom());
    end else begin
      p = $urandom_range(0, 99);
      if (p < 78) door = DOOR_CLOSED;
      else if (p < 84) door = DOOR_OPEN;
      else if (p < 94) door = DOOR_UNKNOWN;
      else door = DOOR_BAD_CODE;
      motion = motion_of_kind(pick_motion_kind(occ_model.state), occ_model.motion_thr);
    end
    send_poll(poll_time, door, motion);
  endtask

  // one register setting followed by a run of random polls
  task automatic run_phase(input logic [CFG_W-1:0] thr_word, input logic [TIME_W-1:0] cd,
                           input logic [TIME_W-1:0] dur, input logic [TIME_W-1:0] still,
                           input int n_items, input bit bursty);
    longint unsigned span;
    longint unsigned span_long;
    int unsigned     burst;
    int unsigned     gap;
    int              sent;
    wait_results_drained();
    write_reg(REG_MOTION_THRESHOLD, thr_word);
    write_reg(REG_COUNTDOWN_LIMIT, cd);
    write_reg(REG_DURATION_LIMIT, dur);
    write_reg(REG_STILLNESS_LIMIT, still);
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
    cfg.valid <= 1'b0;
    phase_count++;
    span = ((cd > still) ? longint'(cd) : longint'(still)) / 2 + 1;
    if (span > STEP_CAP) span = STEP_CAP;
    span_long = longint'(dur) + 1;
    if (span_long > STEP_CAP) span_long = STEP_CAP;
    sent = 0;
    while (sent < n_items) begin
      burst = bursty ? $urandom_range(1, 16) : n_items;
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_random_poll(int'(span), int'(span_long));
        sent++;
      end
      if (bursty && sent < n_items) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          poll.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // walk through every transition but the door opening in stillness, at the reset settings
  task automatic run_directed();
    send_poll(32'd0, DOOR_CLOSED, 16'd61);          // just above threshold starts countdown
    send_poll(32'd100, DOOR_CLOSED, 16'd0);
    send_poll(32'd14999, DOOR_CLOSED, 16'd60);      // equal to threshold does nothing
    send_poll(32'd15000, DOOR_BAD_CODE, 16'd0);     // countdown done
    send_poll(32'd16000, DOOR_CLOSED, 16'd0);       // zero motion is not stillness
    send_poll(32'd16500, DOOR_CLOSED, 16'd59);      // into stillness
    send_poll(32'd17500, DOOR_UNKNOWN, 16'd61);     // back to duration, session kept
    send_poll(32'd18000, DOOR_CLOSED, 16'd1);
    send_poll(32'd138000, DOOR_UNKNOWN, 16'd0);     // stillness alert
    send_poll(32'd140000, DOOR_OPEN, 16'hFFFF);     // open door blocks the start
    send_poll(32'd141000, DOOR_UNKNOWN, 16'hFFFF);
    send_poll(32'd142000, DOOR_CLOSED, 16'hFFFF);
    send_poll(32'd143000, DOOR_OPEN, 16'd1);        // low motion beats the open door
    send_poll(32'd144000, DOOR_CLOSED, 16'd100);
    send_poll(32'd145000, DOOR_OPEN, 16'd0);        // door opened in countdown
    send_poll(32'd146000, DOOR_CLOSED, 16'd200);
    send_poll(32'd161000, DOOR_CLOSED, 16'd60);
    send_poll(32'd162000, DOOR_OPEN, 16'hFFFF);     // door opened in duration
    send_poll(32'hFFFF_F000, DOOR_CLOSED, 16'd1000);
    send_poll(32'h0000_0100, DOOR_CLOSED, 16'd0);   // timer across the wrap
    send_poll(32'h0000_3000, DOOR_CLOSED, 16'd0);
    send_poll(32'h0000_4000, DOOR_CLOSED, 16'd10);
    send_poll(32'd1212288, DOOR_CLOSED, 16'd0);     // both alerts due, duration wins
    send_poll(32'd1300000, DOOR_CLOSED, 16'd61);
    send_poll(32'd1315000, DOOR_OPEN, 16'd61);      // open door beats countdown done
    send_poll(32'd1400000, DOOR_CLOSED, 16'd61);
    send_poll(32'd1415000, DOOR_CLOSED, 16'd61);
    send_poll(32'd2615000, DOOR_CLOSED, 16'd61);    // duration alert from duration
    poll_time = 32'd2615000;
  endtask

  initial begin
    logic [CFG_W-1:0] mix_thr;
    poll.valid        <= 1'b0;
    poll.now_ms       <= '0;
    poll.door_state   <= DOOR_UNKNOWN;
    poll.motion_level <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= REG_MOTION_THRESHOLD;
    cfg.data          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    // small limits, threshold written with junk in the upper bits
    run_phase(32'hABCD_003C, 32'd200, 32'd4000, 32'd600, 110, 1'b1);
    // everything at zero: every timer is already due
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 70, 1'b1);
    // everything at its maximum, sender never idles
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60, 1'b0);
    run_phase(32'd1000, 32'd50, 32'd1500, 32'd300, 120, 1'b1);
    // only motion 1 counts as stillness here
    run_phase(32'd2, 32'd0, 32'hFFFF_FFFF, 32'd100, 80, 1'b1);
    mix_thr = {16'($urandom()), 16'($urandom_range(1, 32'hFFFE))};
    run_phase(mix_thr, $urandom_range(0, 500), $urandom_range(500, 5000),
              $urandom_range(50, 1000), 160, 1'b1);

    wait_results_drained();
    occ_model.flag_leftovers();
    $display("covered %0d polls under reset settings and %0d register settings, %0d results checked",
             occ_model.n_polls, phase_count, occ_model.n_checked);
    $display("transitions: motion above %0d, motion below %0d, door opened %0d, countdown %0d, %s %0d, %s %0d",
             occ_model.reason_hits[0], occ_model.reason_hits[1], occ_model.reason_hits[2],
             occ_model.reason_hits[3], "duration alert", occ_model.reason_hits[4],
             "stillness alert", occ_model.reason_hits[5]);
    if (occ_model.n_errors == 0) begin
      $display("PASS occupancy_stillness_alarm_fsm");
    end else begin
      $display("FAIL occupancy_stillness_alarm_fsm");
    end
    $finish;
  end

endmodule
